FILE: sv/sst_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Tokenizer package
// Token kinds, lexer mode codes, character classes and keyword lookup.
// ---------------------------------------------------------------------------
package sst_pkg;

   localparam logic [6:0] K_IDENT  = 7'd31;
   localparam logic [6:0] K_STRING = 7'd32;
   localparam logic [6:0] K_FLOAT  = 7'd33;
   localparam logic [6:0] K_INT    = 7'd34;
   localparam logic [6:0] K_EOF    = 7'd71;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_STR   = 2'd1;
   localparam logic [1:0] ERR_BLOCK = 2'd2;
   localparam logic [1:0] ERR_CHAR  = 2'd3;

   localparam logic [3:0] M_IDLE        = 4'd0;
   localparam logic [3:0] M_IDENT       = 4'd1;
   localparam logic [3:0] M_INT         = 4'd2;
   localparam logic [3:0] M_INT_DOT     = 4'd3;
   localparam logic [3:0] M_FRAC        = 4'd4;
   localparam logic [3:0] M_EXP_START   = 4'd5;
   localparam logic [3:0] M_EXP_DIG     = 4'd6;
   localparam logic [3:0] M_STR         = 4'd7;
   localparam logic [3:0] M_STR_ESC     = 4'd8;
   localparam logic [3:0] M_OP          = 4'd9;
   localparam logic [3:0] M_LINE_CMT    = 4'd10;
   localparam logic [3:0] M_BLOCK       = 4'd11;
   localparam logic [3:0] M_BLOCK_SLASH = 4'd12;
   localparam logic [3:0] M_BLOCK_STAR  = 4'd13;

   localparam int KW_MAX = 8;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_num(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // Keyword text packed left-aligned in 64 bits; unused tail bytes are zero.
   function automatic logic [6:0] kw_lookup(input logic [63:0] w, input logic [3:0] n);
      logic [6:0] k;
      k = K_IDENT;
      case ({n, w})
         {4'd8, "function"}: k = 7'd0;
         {4'd3, "end", 40'd0}: k = 7'd1;
         {4'd6, "return", 16'd0}: k = 7'd2;
         {4'd2, "if", 48'd0}: k = 7'd3;
         {4'd4, "then", 32'd0}: k = 7'd4;
         {4'd6, "elseif", 16'd0}: k = 7'd5;
         {4'd4, "else", 32'd0}: k = 7'd6;
         {4'd5, "while", 24'd0}: k = 7'd7;
         {4'd2, "do", 48'd0}: k = 7'd8;
         {4'd6, "unless", 16'd0}: k = 7'd9;
         {4'd3, "for", 40'd0}: k = 7'd10;
         {4'd2, "in", 48'd0}: k = 7'd11;
         {4'd5, "break", 24'd0}: k = 7'd12;
         {4'd8, "continue"}: k = 7'd13;
         {4'd6, "struct", 16'd0}: k = 7'd14;
         {4'd3, "and", 40'd0}: k = 7'd15;
         {4'd2, "or", 48'd0}: k = 7'd16;
         {4'd3, "not", 40'd0}: k = 7'd17;
         {4'd3, "nil", 40'd0}: k = 7'd18;
         {4'd4, "true", 32'd0}: k = 7'd19;
         {4'd5, "false", 24'd0}: k = 7'd20;
         {4'd3, "int", 40'd0}: k = 7'd21;
         {4'd5, "float", 24'd0}: k = 7'd22;
         {4'd4, "bool", 32'd0}: k = 7'd23;
         {4'd6, "string", 16'd0}: k = 7'd24;
         {4'd5, "const", 24'd0}: k = 7'd25;
         {4'd4, "enum", 32'd0}: k = 7'd26;
         {4'd3, "try", 40'd0}: k = 7'd27;
         {4'd5, "catch", 24'd0}: k = 7'd28;
         {4'd5, "throw", 24'd0}: k = 7'd29;
         {4'd7, "require", 8'd0}: k = 7'd30;
         default: k = K_IDENT;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

FILE: sv/script_source_tokenizer_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Script source tokenizer
// Streams source bytes in and token beats out, one byte per cycle while req_ready is high.
// ---------------------------------------------------------------------------
//   Channel | Ports             | Direction | Beat
//   request | req_valid/ready   | in        | one source byte, 0 = end
//   response| rsp_valid/ready   | out       | one token or error result
//
// A byte is taken every cycle while the result queue has room for three
// more tokens; the lexer state updates in the same cycle it is accepted.
// Tokens leave the result queue on rsp_ one per cycle while rsp_ready is high.
// A byte can yield up to three tokens, so sustained rate falls below one
// byte per cycle only when output consumption lags or bursts arrive.
// Reset is synchronous; it clears the queue and all lexer state but word_ff.
// ---------------------------------------------------------------------------
module script_source_tokenizer_unit #(
   parameter int OFFSET_WIDTH = 24,
   parameter int LINE_WIDTH   = 16,
   parameter int DEPTH_WIDTH  = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [7:0]              req_source_byte,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [6:0]                   rsp_token_kind,
   output logic [OFFSET_WIDTH-1:0]      rsp_start_offset,
   output logic [OFFSET_WIDTH-1:0]      rsp_text_length,
   output logic [LINE_WIDTH-1:0]        rsp_line_number,
   output logic [1:0]                   rsp_error_code,
   output logic                         rsp_last_of_run
);

   localparam int W = 7 + 2*OFFSET_WIDTH + LINE_WIDTH + 2 + 1;

   logic                       step;
   logic [2:0]                 cnt;
   logic [3*7-1:0]             kinds;
   logic [3*OFFSET_WIDTH-1:0]  starts, lens;
   logic [LINE_WIDTH-1:0]      line;
   logic [3*2-1:0]             errs;
   logic [3*W-1:0]             packed_beats;
   logic [W-1:0]               head;

   assign step = req_valid && req_ready;

   sst_lexer #(
      .OFFSET_WIDTH(OFFSET_WIDTH), .LINE_WIDTH(LINE_WIDTH), .DEPTH_WIDTH(DEPTH_WIDTH)
   ) u_lexer (
      .clock(clock), .reset(reset), .step(step), .in_byte(req_source_byte),
      .tok_count(cnt), .tok_kind(kinds), .tok_start(starts), .tok_len(lens),
      .tok_line(line), .tok_err(errs)
   );

   // Pack each token; mark the final token of this byte.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         packed_beats[W*i +: W] = {kinds[7*i +: 7], starts[OFFSET_WIDTH*i +: OFFSET_WIDTH],
                                   lens[OFFSET_WIDTH*i +: OFFSET_WIDTH], line,
                                   errs[2*i +: 2], (cnt == 3'(i + 1))};
      end
   end

   sst_outq #(.WIDTH(W)) u_outq (
      .clock(clock), .reset(reset), .push_count(step ? cnt : 3'd0),
      .push_data(packed_beats), .room(req_ready), .out_valid(rsp_valid),
      .out_ready(rsp_ready), .out_data(head)
   );

   assign {rsp_token_kind, rsp_start_offset, rsp_text_length, rsp_line_number,
           rsp_error_code, rsp_last_of_run} = head;

`ifndef SYNTHESIS
   // An end byte always closes with an EOF beat.
   a_end_eof: assert property (@(posedge clock) disable iff (reset)
      step && req_source_byte == 8'd0 |-> cnt != 3'd0 &&
      kinds[7*(cnt - 3'd1) +: 7] == sst_pkg::K_EOF)
      else $error("end byte without EOF");
   a_burst: assert property (@(posedge clock) disable iff (reset)
      cnt <= 3'd3)
      else $error("burst too large");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != sst_pkg::ERR_NONE |-> rsp_token_kind == 7'd0)
      else $error("error beat with kind");
`endif

endmodule
`default_nettype wire

FILE: sv/sst_lexer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Tokenizer lexer step
// Registered lexer state plus the single-pass next-state and token logic.
// Produces up to three tokens per byte on a parallel result bus.
// ---------------------------------------------------------------------------
module sst_lexer #(
   parameter int OFFSET_WIDTH = 24,
   parameter int LINE_WIDTH   = 16,
   parameter int DEPTH_WIDTH  = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic [7:0]              in_byte,
   output logic [2:0]                   tok_count,
   output logic [3*7-1:0]               tok_kind,
   output logic [3*OFFSET_WIDTH-1:0]    tok_start,
   output logic [3*OFFSET_WIDTH-1:0]    tok_len,
   output logic [LINE_WIDTH-1:0]        tok_line,
   output logic [3*2-1:0]               tok_err
);

   localparam int KB = sst_pkg::KW_MAX;
   localparam logic [OFFSET_WIDTH-1:0] OMAX = '1;
   localparam logic [LINE_WIDTH-1:0]   LMAX = '1;
   localparam logic [DEPTH_WIDTH-1:0]  DMAX = '1;

   logic [3:0]              mode_ff, mode_in;
   logic [OFFSET_WIDTH-1:0] off_ff, off_in, start_ff, start_in, len_ff, len_in;
   logic [LINE_WIDTH-1:0]   line_ff, line_in;
   logic [7:0]              pend_ff, pend_in, quote_ff, quote_in;
   logic [DEPTH_WIDTH-1:0]  depth_ff, depth_in;
   logic                    err_ff, err_in;
   logic [63:0]             word_ff, word_in;

   logic [OFFSET_WIDTH-1:0] off_inc, start_inc, len_inc, len_inc2;
   logic [LINE_WIDTH-1:0]   line_inc;
   logic [OFFSET_WIDTH:0]   int_end;
   logic [63:0]             word_masked;
   logic [6:0]              word_kind;
   logic                    b_alpha, b_num, b_ws;
   logic                    do_fresh, do_fin;
   logic [7:0]              fresh_b;
   logic [1:0]              n;

   assign off_inc   = (off_ff == OMAX) ? OMAX : off_ff + 1'b1;
   assign start_inc = (start_ff == OMAX) ? OMAX : start_ff + 1'b1;
   assign len_inc   = (len_ff == OMAX) ? OMAX : len_ff + 1'b1;
   assign len_inc2  = (len_inc == OMAX) ? OMAX : len_inc + 1'b1;
   assign line_inc  = (line_ff == LMAX) ? LMAX : line_ff + 1'b1;
   assign int_end   = {1'b0, start_ff} + {1'b0, len_ff};
   assign b_alpha   = sst_pkg::is_alpha(in_byte);
   assign b_num     = sst_pkg::is_num(in_byte);
   assign b_ws      = in_byte == " " || in_byte == 8'h09 || in_byte == 8'h0d;

   always_comb begin
      word_masked = '0;
      for (int i = 0; i < KB; i++) begin
         if (len_ff > OFFSET_WIDTH'(i)) word_masked[63-8*i -: 8] = word_ff[63-8*i -: 8];
      end
   end
   assign word_kind = (len_ff > OFFSET_WIDTH'(KB)) ? sst_pkg::K_IDENT :
                      sst_pkg::kw_lookup(word_masked, len_ff[3:0]);

   always_comb begin
      logic [6:0] single, pair, one;
      logic [7:0] c;
      mode_in = mode_ff; off_in = off_ff; start_in = start_ff; len_in = len_ff;
      line_in = line_ff; pend_in = pend_ff; quote_in = quote_ff; depth_in = depth_ff;
      err_in = err_ff; word_in = word_ff;
      tok_kind = '0; tok_start = '0; tok_len = '0; tok_err = '0;
      n = 2'd0; do_fresh = 1'b0; do_fin = 1'b0; fresh_b = in_byte;
      single = '0; pair = '0; one = '0; c = pend_ff;

      // Emit helper pattern written out per slot index n.
      if (err_ff) begin
         if (in_byte == 8'd0) do_fin = 1'b1;
      end else begin
         case (mode_ff)
            sst_pkg::M_IDENT: begin
               if (b_alpha || b_num) begin
                  for (int i = 0; i < KB; i++) begin
                     if (len_ff == OFFSET_WIDTH'(i)) word_in[63-8*i -: 8] = in_byte;
                  end
                  len_in = len_inc;
               end else begin
                  tok_kind[6:0] = word_kind; tok_start[OFFSET_WIDTH-1:0] = start_ff;
                  tok_len[OFFSET_WIDTH-1:0] = len_ff; n = 2'd1; do_fresh = 1'b1;
               end
            end
            sst_pkg::M_INT: begin
               if (b_num) len_in = len_inc;
               else if (in_byte == ".") mode_in = sst_pkg::M_INT_DOT;
               else if (in_byte == "e" || in_byte == "E") begin
                  mode_in = sst_pkg::M_EXP_START; len_in = len_inc;
               end else begin
                  tok_kind[6:0] = sst_pkg::K_INT; tok_start[OFFSET_WIDTH-1:0] = start_ff;
                  tok_len[OFFSET_WIDTH-1:0] = len_ff; n = 2'd1; do_fresh = 1'b1;
               end
            end
            sst_pkg::M_INT_DOT: begin
               if (b_num) begin
                  mode_in = sst_pkg::M_FRAC; len_in = len_inc2;
               end else begin
                  tok_kind[6:0] = sst_pkg::K_INT; tok_start[OFFSET_WIDTH-1:0] = start_ff;
                  tok_len[OFFSET_WIDTH-1:0] = len_ff; n = 2'd1;
                  start_in = int_end[OFFSET_WIDTH] ? OMAX : int_end[OFFSET_WIDTH-1:0];
                  mode_in = sst_pkg::M_OP; c = ".";
               end
            end
            sst_pkg::M_FRAC: begin
               if (b_num) len_in = len_inc;
               else if (in_byte == "e" || in_byte == "E") begin
                  mode_in = sst_pkg::M_EXP_START; len_in = len_inc;
               end else begin
                  tok_kind[6:0] = sst_pkg::K_FLOAT; tok_start[OFFSET_WIDTH-1:0] = start_ff;
                  tok_len[OFFSET_WIDTH-1:0] = len_ff; n = 2'd1; do_fresh = 1'b1;
               end
            end
            sst_pkg::M_EXP_START, sst_pkg::M_EXP_DIG: begin
               if (b_num || (mode_ff == sst_pkg::M_EXP_START &&
                             (in_byte == "+" || in_byte == "-"))) begin
                  mode_in = sst_pkg::M_EXP_DIG; len_in = len_inc;
               end else begin
                  tok_kind[6:0] = sst_pkg::K_FLOAT; tok_start[OFFSET_WIDTH-1:0] = start_ff;
                  tok_len[OFFSET_WIDTH-1:0] = len_ff; n = 2'd1; do_fresh = 1'b1;
               end
            end
            sst_pkg::M_STR, sst_pkg::M_STR_ESC: begin
               if (in_byte == 8'd0) begin
                  tok_start[OFFSET_WIDTH-1:0] = start_ff; tok_err[1:0] = sst_pkg::ERR_STR;
                  n = 2'd1; do_fin = 1'b1;
               end else if (mode_ff == sst_pkg::M_STR_ESC) begin
                  len_in = len_inc; mode_in = sst_pkg::M_STR;
               end else if (in_byte == quote_ff) begin
                  tok_kind[6:0] = sst_pkg::K_STRING; tok_start[OFFSET_WIDTH-1:0] = start_ff;
                  tok_len[OFFSET_WIDTH-1:0] = len_ff; n = 2'd1; mode_in = sst_pkg::M_IDLE;
               end else begin
                  len_in = len_inc;
                  if (in_byte == 8'h0a) line_in = line_inc;
                  if (in_byte == 8'h5c) mode_in = sst_pkg::M_STR_ESC;
               end
            end
            sst_pkg::M_LINE_CMT: begin
               if (in_byte == 8'h0a || in_byte == 8'd0) do_fresh = 1'b1;
            end
            sst_pkg::M_BLOCK, sst_pkg::M_BLOCK_SLASH, sst_pkg::M_BLOCK_STAR: begin
               if (in_byte == 8'd0) begin
                  tok_start[OFFSET_WIDTH-1:0] = start_ff; tok_err[1:0] = sst_pkg::ERR_BLOCK;
                  n = 2'd1; do_fin = 1'b1;
               end else if (mode_ff == sst_pkg::M_BLOCK_SLASH && in_byte == "*") begin
                  depth_in = (depth_ff == DMAX) ? DMAX : depth_ff + 1'b1;
                  mode_in = sst_pkg::M_BLOCK;
               end else if (mode_ff == sst_pkg::M_BLOCK_STAR && in_byte == "/") begin
                  depth_in = (depth_ff != '0) ? depth_ff - 1'b1 : depth_ff;
                  mode_in = (depth_in == '0) ? sst_pkg::M_IDLE : sst_pkg::M_BLOCK;
               end else begin
                  if (in_byte == 8'h0a) line_in = line_inc;
                  mode_in = (in_byte == "/") ? sst_pkg::M_BLOCK_SLASH :
                            (in_byte == "*") ? sst_pkg::M_BLOCK_STAR : sst_pkg::M_BLOCK;
               end
            end
            sst_pkg::M_OP: ;
            default: do_fresh = 1'b1;
         endcase

         // Resolve a pending operator against the lookahead byte.
         if (mode_ff == sst_pkg::M_OP || mode_in == sst_pkg::M_OP) begin
            if (mode_ff == sst_pkg::M_OP) c = pend_ff;
            mode_in = sst_pkg::M_IDLE;
            case (c)
               ".": begin one = 7'd47; if (in_byte == ".") pair = 7'd46; end
               "+": begin one = 7'd50;
                  if (in_byte == "=") pair = 7'd48; else if (in_byte == "+") pair = 7'd49; end
               "-": begin one = 7'd52;
                  if (in_byte == "=") pair = 7'd51; end
               "*": begin one = 7'd55;
                  if (in_byte == "*") pair = 7'd53; else if (in_byte == "=") pair = 7'd54; end
               "/": begin one = 7'd57; if (in_byte == "=") pair = 7'd56; end
               "%": begin one = 7'd59; if (in_byte == "=") pair = 7'd58; end
               "=": begin one = 7'd61; if (in_byte == "=") pair = 7'd60; end
               "!": begin one = 7'd17; if (in_byte == "=") pair = 7'd62; end
               "<": begin one = 7'd65;
                  if (in_byte == "=") pair = 7'd63; else if (in_byte == "<") pair = 7'd64; end
               ">": begin one = 7'd68;
                  if (in_byte == "=") pair = 7'd66; else if (in_byte == ">") pair = 7'd67; end
               "&": begin one = 7'd69; if (in_byte == "&") pair = 7'd15; end
               "|": begin one = 7'd70; if (in_byte == "|") pair = 7'd16; end
               default: one = '0;
            endcase
            if ((c == "-" && in_byte == "-") || (c == "/" && in_byte == "/")) begin
               mode_in = sst_pkg::M_LINE_CMT;
            end else if (c == "/" && in_byte == "*") begin
               mode_in = sst_pkg::M_BLOCK; depth_in = DEPTH_WIDTH'(1);
            end else if (pair != '0) begin
               tok_kind[7*n +: 7] = pair; tok_start[OFFSET_WIDTH*n +: OFFSET_WIDTH] = start_in;
               tok_len[OFFSET_WIDTH*n +: OFFSET_WIDTH] = OFFSET_WIDTH'(2); n = n + 2'd1;
            end else begin
               tok_kind[7*n +: 7] = one; tok_start[OFFSET_WIDTH*n +: OFFSET_WIDTH] = start_in;
               tok_len[OFFSET_WIDTH*n +: OFFSET_WIDTH] = OFFSET_WIDTH'(1); n = n + 2'd1;
               do_fresh = 1'b1;
            end
         end

         // Start of a new token or a separator.
         if (do_fresh) begin
            mode_in = sst_pkg::M_IDLE;
            case (single)
               default: ;
            endcase
            if (fresh_b == 8'd0) do_fin = 1'b1;
            else if (b_ws) ;
            else if (fresh_b == 8'h0a) line_in = line_inc;
            else if (b_alpha) begin
               mode_in = sst_pkg::M_IDENT; start_in = off_ff; len_in = OFFSET_WIDTH'(1);
               word_in[63:56] = fresh_b;
            end else if (b_num) begin
               mode_in = sst_pkg::M_INT; start_in = off_ff; len_in = OFFSET_WIDTH'(1);
            end else if (fresh_b == 8'h22 || fresh_b == 8'h27) begin
               mode_in = sst_pkg::M_STR; quote_in = fresh_b;
               start_in = off_inc; len_in = '0;
            end else begin
               case (fresh_b)
                  "(": single = 7'd35; ")": single = 7'd36;
                  "[": single = 7'd37; "]": single = 7'd38;
                  "{": single = 7'd39; "}": single = 7'd40;
                  ",": single = 7'd41; ":": single = 7'd42;
                  "?": single = 7'd43; "~": single = 7'd44;
                  "^": single = 7'd45;
                  default: single = '0;
               endcase
               if (fresh_b == "." || fresh_b == "+" || fresh_b == "-" || fresh_b == "*" ||
                   fresh_b == "/" || fresh_b == "%" || fresh_b == "=" || fresh_b == "!" ||
                   fresh_b == "<" || fresh_b == ">" || fresh_b == "&" || fresh_b == "|") begin
                  mode_in = sst_pkg::M_OP; pend_in = fresh_b; start_in = off_ff;
               end else begin
                  tok_kind[7*n +: 7] = single;
                  tok_start[OFFSET_WIDTH*n +: OFFSET_WIDTH] = off_ff;
                  tok_len[OFFSET_WIDTH*n +: OFFSET_WIDTH] = OFFSET_WIDTH'(1);
                  if (single == '0) begin
                     tok_err[2*n +: 2] = sst_pkg::ERR_CHAR; err_in = 1'b1;
                  end
                  n = n + 2'd1;
               end
            end
         end
         if (tok_err != '0) begin
            err_in = 1'b1;
            if (!do_fin) mode_in = sst_pkg::M_IDLE;
         end
      end

      if (in_byte != 8'd0) off_in = off_inc;
      tok_count = {1'b0, n};
      if (do_fin) begin
         tok_kind[7*n +: 7] = sst_pkg::K_EOF;
         tok_start[OFFSET_WIDTH*n +: OFFSET_WIDTH] = off_ff;
         tok_len[OFFSET_WIDTH*n +: OFFSET_WIDTH] = '0;
         tok_err[2*n +: 2] = sst_pkg::ERR_NONE;
         tok_count = {1'b0, n} + 3'd1;
         mode_in = sst_pkg::M_IDLE; off_in = '0; line_in = LINE_WIDTH'(1);
         start_in = '0; pend_in = '0; len_in = '0; depth_in = '0;
         quote_in = '0; err_in = 1'b0;
      end
   end

   // All tokens of one byte carry the line held before that byte; a newline
   // never precedes a token within the same byte.
   assign tok_line = line_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sst_pkg::M_IDLE; off_ff <= '0; line_ff <= LINE_WIDTH'(1);
         start_ff <= '0; pend_ff <= '0; len_ff <= '0; depth_ff <= '0;
         quote_ff <= '0; err_ff <= 1'b0;
      end else if (step) begin
         mode_ff <= mode_in; off_ff <= off_in; line_ff <= line_in;
         start_ff <= start_in; pend_ff <= pend_in; len_ff <= len_in;
         depth_ff <= depth_in; quote_ff <= quote_in; err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) word_ff <= word_in;
   end

endmodule
`default_nettype wire

FILE: sv/sst_outq.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Tokenizer result queue
// Small FIFO that serializes the token bursts of the lexer onto one channel.
// ---------------------------------------------------------------------------
module sst_outq #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [2:0]       push_count,
   input  wire logic [3*WIDTH-1:0] push_data,
   output logic                  room,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [WIDTH-1:0]      out_data
);

   logic [WIDTH-1:0] mem_ff [8];
   logic [2:0]       rd_ff, wr_ff;
   logic [3:0]       cnt_ff;
   logic             pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   // Accept a byte only when a worst-case burst of three still fits.
   assign room      = cnt_ff <= 4'd5;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (3'(i) < push_count) mem_ff[wr_ff + 3'(i)] <= push_data[WIDTH*i +: WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0; wr_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_ff + push_count;
         rd_ff  <= rd_ff + {2'b0, pop};
         cnt_ff <= cnt_ff + {1'b0, push_count} - {3'b0, pop};
      end
   end

endmodule
`default_nettype wire
